// ===== sv/xte_pkg.sv =====
// Shared types, command codes and sizes for the XML text entity escaper.
`default_nettype none
package xte_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // command codes passed from the front part to the back part
    localparam logic [2:0] CMD_CHAR = 3'd0;
    localparam logic [2:0] CMD_LT   = 3'd1;
    localparam logic [2:0] CMD_GT   = 3'd2;
    localparam logic [2:0] CMD_AMP  = 3'd3;
    localparam logic [2:0] CMD_DEC  = 3'd4;
    localparam logic [2:0] CMD_HEX  = 3'd5;
    localparam logic [2:0] CMD_NUL  = 3'd6;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_OTHER = 2'd1;
    localparam logic [1:0] MODE_NODE  = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [20:0] val;
        logic        last;
    } cmd_t;

endpackage
`default_nettype wire

// ===== sv/xte_fifo.sv =====
// Short command queue between the classifying front and the serializing back.
`default_nettype none
module xte_fifo
    import xte_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        push,
    input  cmd_t       push_data,
    output logic       full,
    output logic       not_empty,
    input  wire        pop,
    output cmd_t       head_data
);

    cmd_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("command pushed into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("command popped from empty queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== sv/xte_front.sv =====
// Front part: accepts items, collects UTF-8 sequences and issues escape commands.
`default_nettype none
module xte_front
    import xte_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire        s_kind,
    input  wire  [7:0] s_data_byte,
    input  wire        cfg_we,
    input  wire  [1:0] cfg_wdata,
    input  wire        fifo_full,
    output logic       push,
    output cmd_t       push_data
);

    logic [1:0] mode_reg;
    logic       busy_reg, busy_next;
    logic       at_end_reg, at_end_next;
    logic [7:0] pend_q_reg [4];
    logic [7:0] pend_q_next [4];
    logic [2:0] pend_len_reg, pend_len_next;
    logic [7:0] seq_bytes_reg [4];
    logic [7:0] seq_bytes_next [4];
    logic [2:0] seq_count_reg, seq_count_next;
    logic [2:0] seq_need_reg, seq_need_next;
    cmd_t       hold_reg, hold_next;
    logic       hold_v_reg, hold_v_next;

    logic       step;
    logic [7:0] b;
    logic       node_mode, doc_on;
    logic [7:0] rest [4];
    logic [7:0] sb_n [4];
    logic [2:0] cnt_n;
    logic [20:0] v;
    logic       new_v;
    cmd_t       new_cmd;
    logic       do_rej;
    logic [7:0] rej_sb [4];
    logic [2:0] rej_cnt;
    logic [7:0] rej_rest [4];
    logic [2:0] rej_rlen;
    logic [2:0] jdx;
    logic [3:0] tot;
    logic       done;

    function automatic logic is_xml_char(input logic [20:0] x);
        if (x < 21'h100) begin
            return (x == 21'h9) || (x == 21'hA) || (x == 21'hD) || (x >= 21'h20);
        end
        return (x <= 21'hD7FF) || (x >= 21'hE000 && x <= 21'hFFFD) ||
               (x >= 21'h10000 && x <= 21'h10FFFF);
    endfunction

    assign s_ready   = !busy_reg;
    assign node_mode = (mode_reg == MODE_NODE);
    assign doc_on    = (mode_reg != MODE_NONE);
    assign step      = busy_reg && !fifo_full;

    always_comb begin
        busy_next      = busy_reg;
        at_end_next    = at_end_reg;
        pend_q_next    = pend_q_reg;
        pend_len_next  = pend_len_reg;
        seq_bytes_next = seq_bytes_reg;
        seq_count_next = seq_count_reg;
        seq_need_next  = seq_need_reg;
        hold_next      = hold_reg;
        hold_v_next    = hold_v_reg;
        push           = 1'b0;
        push_data      = hold_reg;
        new_v          = 1'b0;
        new_cmd        = '0;
        do_rej         = 1'b0;
        done           = 1'b0;
        b              = pend_q_reg[0];
        rest[0]        = pend_q_reg[1];
        rest[1]        = pend_q_reg[2];
        rest[2]        = pend_q_reg[3];
        rest[3]        = 8'h00;
        sb_n           = seq_bytes_reg;
        sb_n[seq_count_reg[1:0]] = b;
        cnt_n          = seq_count_reg + 3'd1;
        rej_sb         = seq_bytes_reg;
        rej_cnt        = seq_count_reg;
        rej_rest       = rest;
        rej_rlen       = 3'd0;
        jdx            = 3'd0;
        tot            = 4'd0;
        v              = '0;
        unique case (seq_need_reg)
            3'd2:    v = {10'd0, sb_n[0][4:0], sb_n[1][5:0]};
            3'd3:    v = {5'd0, sb_n[0][3:0], sb_n[1][5:0], sb_n[2][5:0]};
            default: v = {sb_n[0][2:0], sb_n[1][5:0], sb_n[2][5:0], sb_n[3][5:0]};
        endcase

        if (s_valid && s_ready) begin
            busy_next = 1'b1;
            if (s_kind) begin
                at_end_next   = 1'b1;
                pend_len_next = 3'd0;
            end else begin
                at_end_next    = 1'b0;
                pend_q_next[0] = s_data_byte;
                pend_len_next  = 3'd1;
            end
        end else if (step) begin
            if (pend_len_reg != 3'd0) begin
                pend_q_next   = rest;
                pend_len_next = pend_len_reg - 3'd1;
                if (seq_need_reg != 3'd0) begin
                    seq_bytes_next = sb_n;
                    seq_count_next = cnt_n;
                    if (cnt_n >= seq_need_reg) begin
                        if (is_xml_char(v)) begin
                            new_v          = 1'b1;
                            new_cmd.kind   = CMD_HEX;
                            new_cmd.val    = v;
                            seq_count_next = 3'd0;
                            seq_need_next  = 3'd0;
                        end else begin
                            do_rej   = 1'b1;
                            rej_sb   = sb_n;
                            rej_cnt  = cnt_n;
                            rej_rlen = pend_len_reg - 3'd1;
                        end
                    end
                end else if (b == 8'h3C) begin
                    new_v = 1'b1;
                    new_cmd.kind = CMD_LT;
                end else if (b == 8'h3E) begin
                    new_v = 1'b1;
                    new_cmd.kind = CMD_GT;
                end else if (b == 8'h26) begin
                    new_v = 1'b1;
                    new_cmd.kind = CMD_AMP;
                end else if ((b >= 8'h20 && b < 8'h80) || b == 8'h0A || b == 8'h09 ||
                             (node_mode && b == 8'h0D)) begin
                    new_v = 1'b1;
                    new_cmd.kind = CMD_CHAR;
                    new_cmd.val  = {13'd0, b};
                end else if (b >= 8'h80) begin
                    if (doc_on) begin
                        new_v = 1'b1;
                        new_cmd.kind = CMD_CHAR;
                        new_cmd.val  = {13'd0, b};
                    end else if (b < 8'hC0 || b >= 8'hF8) begin
                        new_v = 1'b1;
                        new_cmd.kind = CMD_DEC;
                        new_cmd.val  = {13'd0, b};
                    end else begin
                        seq_bytes_next[0] = b;
                        seq_count_next    = 3'd1;
                        seq_need_next     = (b < 8'hE0) ? 3'd2 : ((b < 8'hF0) ? 3'd3 : 3'd4);
                    end
                end else if (b == 8'h0D) begin
                    new_v = 1'b1;
                    new_cmd.kind = CMD_DEC;
                    new_cmd.val  = 21'd13;
                end
            end else if (at_end_reg && seq_need_reg != 3'd0) begin
                // flush an incomplete sequence as invalid
                do_rej = 1'b1;
            end else if (at_end_reg) begin
                new_v        = 1'b1;
                new_cmd.kind = CMD_NUL;
                at_end_next  = 1'b0;
            end else begin
                done = 1'b1;
            end
        end

        if (do_rej) begin
            for (int k = 0; k < 4; k++) begin
                jdx = 3'(k) - (rej_cnt - 3'd1);
                if (3'(k) + 3'd1 < rej_cnt) begin
                    pend_q_next[k] = rej_sb[k+1];
                end else begin
                    pend_q_next[k] = rej_rest[jdx[1:0]];
                end
            end
            tot            = {1'b0, rej_cnt - 3'd1} + {1'b0, rej_rlen};
            pend_len_next  = (tot > 4'd4) ? 3'd4 : tot[2:0];
            seq_count_next = 3'd0;
            seq_need_next  = 3'd0;
            new_v          = 1'b1;
            new_cmd.kind   = CMD_DEC;
            new_cmd.val    = {13'd0, rej_sb[0]};
        end

        // hold the newest command until we know whether it ends the item
        if (new_v) begin
            push        = hold_v_reg;
            push_data   = hold_reg;
            hold_next   = new_cmd;
            hold_v_next = 1'b1;
        end else if (done) begin
            push           = hold_v_reg;
            push_data      = hold_reg;
            push_data.last = 1'b1;
            hold_v_next    = 1'b0;
            busy_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_NONE;
            busy_reg      <= 1'b0;
            at_end_reg    <= 1'b0;
            pend_len_reg  <= '0;
            seq_count_reg <= '0;
            seq_need_reg  <= '0;
            hold_v_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= (cfg_wdata == MODE_RSVD) ? MODE_OTHER : cfg_wdata;
            end
            busy_reg      <= busy_next;
            at_end_reg    <= at_end_next;
            pend_len_reg  <= pend_len_next;
            seq_count_reg <= seq_count_next;
            seq_need_reg  <= seq_need_next;
            hold_v_reg    <= hold_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_q_reg    <= pend_q_next;
        seq_bytes_reg <= seq_bytes_next;
        hold_reg      <= hold_next;
    end

endmodule
`default_nettype wire

// ===== sv/xte_back.sv =====
// Back part: expands commands into bytes, one per cycle unless stalled.
`default_nettype none
module xte_back
    import xte_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        fifo_valid,
    input  cmd_t       fifo_data,
    output logic       pop,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_string_end,
    output logic       m_run_last
);

    cmd_t       cur_reg;
    logic       cur_v_reg;
    logic [3:0] idx_reg;
    logic       m_valid_reg;
    logic [7:0] m_out_byte_reg;
    logic       m_string_end_reg;
    logic       m_run_last_reg;

    logic        can_emit, fin;
    logic [3:0]  len;
    logic [7:0]  ch;
    logic [7:0]  dv;
    logic [1:0]  hund;
    logic [7:0]  rem;
    logic [15:0] tprod;
    logic [3:0]  tens, ones;
    logic [1:0]  nd;
    logic [3:0]  dig [3];
    logic [1:0]  dsel;
    logic [2:0]  nh;
    logic [3:0]  nib;
    logic [2:0]  hpos;
    logic [3:0]  p;

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

    assign dv    = cur_reg.val[7:0];
    assign hund  = (dv >= 8'd200) ? 2'd2 : ((dv >= 8'd100) ? 2'd1 : 2'd0);
    assign rem   = dv - (8'(hund) * 8'd100);
    assign tprod = {9'd0, rem[6:0]} * 16'd205;
    assign tens  = tprod[14:11];
    assign ones  = 4'(rem - (8'(tens) * 8'd10));
    assign nd    = (dv >= 8'd100) ? 2'd3 : ((dv >= 8'd10) ? 2'd2 : 2'd1);
    assign dig[0] = {2'd0, hund};
    assign dig[1] = tens;
    assign dig[2] = ones;

    assign nh = cur_reg.val[20]              ? 3'd6 :
                (cur_reg.val[19:16] != 4'd0) ? 3'd5 :
                (cur_reg.val[15:12] != 4'd0) ? 3'd4 :
                (cur_reg.val[11:8]  != 4'd0) ? 3'd3 :
                (cur_reg.val[7:4]   != 4'd0) ? 3'd2 : 3'd1;

    always_comb begin
        len  = 4'd1;
        ch   = 8'h00;
        p    = 4'd0;
        dsel = 2'd0;
        hpos = 3'd0;
        nib  = 4'd0;
        unique case (cur_reg.kind)
            CMD_CHAR: begin
                len = 4'd1;
                ch  = cur_reg.val[7:0];
            end
            CMD_LT, CMD_GT: begin
                len = 4'd4;
                case (idx_reg)
                    4'd0:    ch = 8'h26;
                    4'd1:    ch = (cur_reg.kind == CMD_LT) ? 8'h6C : 8'h67;
                    4'd2:    ch = 8'h74;
                    default: ch = 8'h3B;
                endcase
            end
            CMD_AMP: begin
                len = 4'd5;
                case (idx_reg)
                    4'd0:    ch = 8'h26;
                    4'd1:    ch = 8'h61;
                    4'd2:    ch = 8'h6D;
                    4'd3:    ch = 8'h70;
                    default: ch = 8'h3B;
                endcase
            end
            CMD_DEC: begin
                len = 4'd3 + {2'd0, nd};
                p   = idx_reg - 4'd2;
                dsel = 2'd3 - nd + p[1:0];
                if (idx_reg == 4'd0) begin
                    ch = 8'h26;
                end else if (idx_reg == 4'd1) begin
                    ch = 8'h23;
                end else if (idx_reg == len - 4'd1) begin
                    ch = 8'h3B;
                end else begin
                    ch = 8'h30 + {4'd0, dig[dsel]};
                end
            end
            CMD_HEX: begin
                len  = 4'd4 + {1'b0, nh};
                p    = idx_reg - 4'd3;
                hpos = nh - 3'd1 - p[2:0];
                case (hpos)
                    3'd0:    nib = cur_reg.val[3:0];
                    3'd1:    nib = cur_reg.val[7:4];
                    3'd2:    nib = cur_reg.val[11:8];
                    3'd3:    nib = cur_reg.val[15:12];
                    3'd4:    nib = cur_reg.val[19:16];
                    default: nib = {3'd0, cur_reg.val[20]};
                endcase
                if (idx_reg == 4'd0) begin
                    ch = 8'h26;
                end else if (idx_reg == 4'd1) begin
                    ch = 8'h23;
                end else if (idx_reg == 4'd2) begin
                    ch = 8'h78;
                end else if (idx_reg == len - 4'd1) begin
                    ch = 8'h3B;
                end else begin
                    ch = hex_ascii(nib);
                end
            end
            default: begin
                len = 4'd1;
                ch  = 8'h00;
            end
        endcase
    end

    assign can_emit = !m_valid_reg || m_ready;
    assign fin      = cur_v_reg && can_emit && (idx_reg == len - 4'd1);
    assign pop      = fifo_valid && (!cur_v_reg || fin);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_v_reg   <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                cur_v_reg <= 1'b1;
                idx_reg   <= '0;
            end else if (fin) begin
                cur_v_reg <= 1'b0;
            end else if (cur_v_reg && can_emit) begin
                idx_reg <= idx_reg + 4'd1;
            end
            if (can_emit) begin
                m_valid_reg <= cur_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= fifo_data;
        end
        if (can_emit && cur_v_reg) begin
            m_out_byte_reg   <= ch;
            m_string_end_reg <= (cur_reg.kind == CMD_NUL);
            m_run_last_reg   <= cur_reg.last && (idx_reg == len - 4'd1);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_string_end = m_string_end_reg;
    assign m_run_last   = m_run_last_reg;

endmodule
`default_nettype wire

// ===== sv/xml_text_entity_escaper.sv =====
// Top level of the XML text entity escaper.
// Escapes a text byte stream for XML: '<' '>' '&' become entities, CR
// outside node mode becomes a decimal reference, and with no document
// mode invalid UTF-8 lead bytes become decimal references and valid
// UTF-8 sequences become upper-case hex character references. The front
// part takes one item at a time, examines the input byte plus any bytes
// requeued after a rejected sequence, then closes the item; it stalls
// while the queue is full. The back part writes one output byte per
// cycle while m_ready allows; a four-entry command queue lets the front
// run ahead. The user must write doc_mode through cfg_we/cfg_wdata while
// the block is idle; it is not enforced. A value of 3 acts as 1.
`default_nettype none
module xml_text_entity_escaper
    import xte_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_we,
    input  wire  [1:0] cfg_wdata,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire        s_kind,
    input  wire  [7:0] s_data_byte,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_string_end,
    output logic       m_run_last
);

    logic fifo_full, fifo_valid, push, pop;
    cmd_t push_data, head_data;

    xte_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_data   (push_data)
    );

    xte_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .not_empty (fifo_valid),
        .pop       (pop),
        .head_data (head_data)
    );

    xte_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fifo_valid   (fifo_valid),
        .fifo_data    (head_data),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_string_end (m_string_end),
        .m_run_last   (m_run_last)
    );

endmodule
`default_nettype wire

// ===== test/xml_text_entity_escaper_test.sv =====
// Self-checking testbench for the XML text entity escaper.
`timescale 1ns / 1ps
module xml_text_entity_escaper_test;
    import xte_pkg::*;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_kind = 1'b0;
    logic [7:0] s_data_byte = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_string_end;
    logic       m_run_last;

    xml_text_entity_escaper dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_data_byte(s_data_byte), .m_valid(m_valid), .m_ready(m_ready),
        .m_out_byte(m_out_byte), .m_string_end(m_string_end),
        .m_run_last(m_run_last)
    );

    always #5 aclk = ~aclk;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } text_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       str_end;
        logic       last;
    } esc_char_t;

    text_item_t pending_items[$];
    esc_char_t  expected_chars[$];
    int         errors = 0;
    logic       hold_off = 1'b0;
    logic       stim_done = 1'b0;

    // predictor state
    logic [1:0] mode_q = MODE_NONE;
    logic [7:0] seq_b[4];
    int         seq_cnt = 0;
    int         seq_len = 0;
    logic [7:0] requeue[$];

    function automatic void emit(logic [7:0] c);
        expected_chars.push_back('{c, 1'b0, 1'b0});
    endfunction

    function automatic void emit_str(string s);
        for (int i = 0; i < s.len(); i++) emit(s[i]);
    endfunction

    function automatic void emit_dec(int v);
        emit_str($sformatf("&#%0d;", v));
    endfunction

    function automatic bit xml_char_ok(int v);
        if (v < 'h100) return v == 9 || v == 10 || v == 13 || v >= 'h20;
        return v <= 'hD7FF || (v >= 'hE000 && v <= 'hFFFD) ||
               (v >= 'h10000 && v <= 'h10FFFF);
    endfunction

    function automatic void reject_sequence();
        logic [7:0] tmp[$];
        emit_dec(seq_b[0]);
        for (int i = 1; i < seq_cnt; i++) tmp.push_back(seq_b[i]);
        foreach (requeue[i]) tmp.push_back(requeue[i]);
        requeue = tmp;
        seq_cnt = 0;
        seq_len = 0;
    endfunction

    function automatic void escape_byte(logic [7:0] b);
        int v;
        string hs;
        if (seq_len != 0) begin
            seq_b[seq_cnt] = b;
            seq_cnt++;
            if (seq_cnt >= seq_len) begin
                if (seq_len == 2)
                    v = (int'(seq_b[0] & 8'h1F) << 6) | (seq_b[1] & 8'h3F);
                else if (seq_len == 3)
                    v = (int'(seq_b[0] & 8'h0F) << 12) | (int'(seq_b[1] & 8'h3F) << 6)
                        | (seq_b[2] & 8'h3F);
                else
                    v = (int'(seq_b[0] & 8'h07) << 18) | (int'(seq_b[1] & 8'h3F) << 12)
                        | (int'(seq_b[2] & 8'h3F) << 6) | (seq_b[3] & 8'h3F);
                if (xml_char_ok(v)) begin
                    // hex digits in upper case
                    hs = $sformatf("%0h", v);
                    emit_str({"&#x", hs.toupper(), ";"});
                    seq_cnt = 0;
                    seq_len = 0;
                end else begin
                    reject_sequence();
                end
            end
            return;
        end
        if (b == "<") emit_str("&lt;");
        else if (b == ">") emit_str("&gt;");
        else if (b == "&") emit_str("&amp;");
        else if ((b >= 8'h20 && b < 8'h80) || b == 8'h0A || b == 8'h09 ||
                 (mode_q == MODE_NODE && b == 8'h0D)) emit(b);
        else if (b >= 8'h80) begin
            if (mode_q != MODE_NONE) emit(b);
            else if (b < 8'hC0 || b >= 8'hF8) emit_dec(b);
            else begin
                seq_b[0] = b;
                seq_cnt = 1;
                seq_len = b < 8'hE0 ? 2 : (b < 8'hF0 ? 3 : 4);
            end
        end else if (b == 8'h0D) emit_dec(13);
    endfunction

    function automatic void predict_escape(text_item_t it);
        int n0;
        logic [7:0] b;
        n0 = expected_chars.size();
        requeue.delete();
        if (!it.kind) requeue.push_back(it.data);
        forever begin
            while (requeue.size() > 0) begin
                b = requeue.pop_front();
                escape_byte(b);
            end
            if (it.kind && seq_len != 0) reject_sequence();
            else break;
        end
        if (it.kind) expected_chars.push_back('{8'h00, 1'b1, 1'b0});
        if (expected_chars.size() > n0)
            expected_chars[expected_chars.size()-1].last = 1'b1;
    endfunction

    // the accept check at negedge uses values sampled at the prior posedge
    logic s_acc = 1'b0;
    always @(posedge aclk) s_acc <= s_valid && s_ready;

    // driver: offer items with random gaps, valid held until accepted
    int gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_acc) begin
                predict_escape('{s_kind, s_data_byte});
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                  : $urandom_range(0, 2);
                if ($urandom_range(0, 2) == 0) gap = 0;
            end
            if (s_valid && !s_acc) begin
                // hold
            end else if (gap > 0) begin
                gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                text_item_t it;
                it = pending_items.pop_front();
                s_kind <= it.kind;
                s_data_byte <= it.data;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    int rgap = 0;
    always @(negedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else if (rgap > 0) begin
            rgap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rgap = ($urandom_range(0, 12) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected item byte=%h end=%b last=%b", $time,
                         m_out_byte, m_string_end, m_run_last);
                errors++;
            end else begin
                esc_char_t e;
                e = expected_chars.pop_front();
                if (e.ch !== m_out_byte || e.str_end !== m_string_end ||
                    e.last !== m_run_last) begin
                    $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                             e.ch, e.str_end, e.last, m_out_byte, m_string_end,
                             m_run_last);
                    errors++;
                end
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h3C;
            1: return 8'h3E;
            2: return 8'h26;
            3: return 8'h0D;
            4: return 8'($urandom_range(0, 31));
            5, 6: return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(32, 127));
        endcase
    endfunction

    function automatic void add_utf8_seq();
        int n;
        logic [7:0] lead;
        n = $urandom_range(2, 4);
        lead = n == 2 ? (8'hC0 | 8'($urandom_range(0, 31))) :
               n == 3 ? (8'hE0 | 8'($urandom_range(0, 15))) :
                        (8'hF0 | 8'($urandom_range(0, 7)));
        pending_items.push_back('{1'b0, lead});
        for (int i = 1; i < n; i++)
            pending_items.push_back('{1'b0, ($urandom_range(0, 7) == 0) ?
                                    8'($urandom) : (8'h80 | 8'($urandom_range(0, 63)))});
    endfunction

    task automatic run_phase(logic [1:0] m, bit directed);
        while (!aclk) @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(negedge aclk);
        cfg_we <= 1'b0;
        mode_q = (m == MODE_RSVD) ? MODE_OTHER : m;
        if (directed) begin
            text_item_t d[$];
            d = '{'{1'b0, 8'h00}, '{1'b0, 8'hFF}, '{1'b0, 8'h3C}, '{1'b0, 8'h3E},
                  '{1'b0, 8'h26}, '{1'b0, 8'h0D}, '{1'b0, 8'h09}, '{1'b0, 8'h0A},
                  '{1'b0, 8'h7F}, '{1'b0, 8'h80}, '{1'b0, 8'hC3}, '{1'b0, 8'hA9},
                  '{1'b0, 8'hED}, '{1'b0, 8'hA0}, '{1'b0, 8'h80}, '{1'b0, 8'hF0},
                  '{1'b0, 8'h9F}, '{1'b0, 8'h98}, '{1'b0, 8'h80}, '{1'b0, 8'hC0},
                  '{1'b0, 8'h00}, '{1'b0, 8'hE2}, '{1'b0, 8'h41}, '{1'b1, 8'h00}};
            foreach (d[i]) pending_items.push_back(d[i]);
        end else begin
            repeat (4) begin
                if (m == MODE_NONE && $urandom_range(0, 1)) add_utf8_seq();
                else pending_items.push_back('{1'b0, pick_byte()});
                if ($urandom_range(0, 7) == 0)
                    pending_items.push_back('{1'b1, 8'($urandom)});
            end
            pending_items.push_back('{1'b0, 8'hF4});
            pending_items.push_back('{1'b1, 8'h00});
        end
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_chars.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        run_phase(MODE_NONE, 1);
        run_phase(MODE_NODE, 1);
        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        fork
            run_phase(MODE_RSVD, 1);
            begin
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
        run_phase(MODE_OTHER, 0);
        run_phase(MODE_NONE, 0);
        run_phase(MODE_NODE, 0);
        run_phase(MODE_NONE, 0);
        run_phase(MODE_OTHER, 0);
        run_phase(MODE_NONE, 0);
        if (errors == 0 && expected_chars.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
